>>> rtl/gsbt_pkg.sv
// ----------------------------------------------------------------------------
// gsbt_pkg: shared types and constants for the gyro still bias tracker
// Register indexes, register reset values and the control structs
// passed between the tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gsbt_pkg;

  // Configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register field widths
  localparam int THRESH_W = 15;
  localparam int COUNT_W  = 16;
  localparam int ALPHA_W  = 16;

  // Fraction bits of the bias estimate
  localparam int FRAC_W = 16;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOTION_THRESHOLD = 2'd0,
    REG_STILL_SAMPLES    = 2'd1,
    REG_SMOOTHING_ALPHA  = 2'd2
  } cfg_reg_t;

  // Register reset values
  localparam logic [THRESH_W-1:0] THRESH_RST = 15'd128;
  localparam logic [COUNT_W-1:0]  COUNT_RST  = 16'd2000;
  localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 16'd65528;

  // Current register contents
  typedef struct packed {
    logic [THRESH_W-1:0] motion_threshold;
    logic [COUNT_W-1:0]  still_samples;
    logic [ALPHA_W-1:0]  smoothing_alpha;
  } cfg_t;

  // Per-sample decision of the stillness logic
  typedef struct packed {
    logic moving;
    logic track;
  } still_ctl_t;

endpackage

`default_nettype wire

>>> rtl/gsbt_ifs.sv
// ----------------------------------------------------------------------------
// gsbt_ifs: channel interfaces of the gyro still bias tracker
// Sample input channel, corrected output channel and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsbt_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] rate_x;
  logic signed [SAMPLE_WIDTH-1:0] rate_y;
  logic signed [SAMPLE_WIDTH-1:0] rate_z;

  modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
  modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

interface gsbt_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] fixed_x;
  logic signed [SAMPLE_WIDTH-1:0] fixed_y;
  logic signed [SAMPLE_WIDTH-1:0] fixed_z;
  logic                           tracking;

  modport source (output valid, output fixed_x, output fixed_y, output fixed_z,
                  output tracking, input ready);
  modport sink   (input valid, input fixed_x, input fixed_y, input fixed_z,
                  input tracking, output ready);
endinterface

interface gsbt_cfg_if import gsbt_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/gsbt_cfg_regs.sv
// ----------------------------------------------------------------------------
// gsbt_cfg_regs: configuration register file
// Holds threshold, still sample count and smoothing weight; writes are
// taken every cycle, unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module gsbt_cfg_regs import gsbt_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  gsbt_cfg_if.sink    cfg_ch,
  output cfg_t        cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg_o        = cfg_r;

  // Decode the register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_MOTION_THRESHOLD: cfg_nxt.motion_threshold = cfg_ch.data[THRESH_W-1:0];
        REG_STILL_SAMPLES:    cfg_nxt.still_samples    = cfg_ch.data[COUNT_W-1:0];
        REG_SMOOTHING_ALPHA:  cfg_nxt.smoothing_alpha  = cfg_ch.data[ALPHA_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motion_threshold <= THRESH_RST;
      cfg_r.still_samples    <= COUNT_RST;
      cfg_r.smoothing_alpha  <= ALPHA_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/gsbt_still_ctl.sv
// ----------------------------------------------------------------------------
// gsbt_still_ctl: motion detection and stillness counter
// Flags a sample as moving when any axis leaves the threshold band, counts
// consecutive still samples and decides when the bias follows the sample.
// ----------------------------------------------------------------------------
`default_nettype none

module gsbt_still_ctl import gsbt_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           update_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] rate_x_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] rate_y_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] rate_z_i,
  input  wire logic        [THRESH_W-1:0]     thresh_i,
  input  wire logic        [COUNT_W-1:0]      still_samples_i,
  output still_ctl_t                          ctl_o
);

  // Compare width covers both the sample and the negated threshold
  localparam int CW = ((SAMPLE_WIDTH > THRESH_W) ? SAMPLE_WIDTH : THRESH_W) + 2;

  logic signed [CW-1:0] thr_pos;
  logic signed [CW-1:0] thr_neg;
  logic signed [CW-1:0] rx;
  logic signed [CW-1:0] ry;
  logic signed [CW-1:0] rz;
  logic                 moving;
  logic                 reached;
  logic [COUNT_W-1:0]   cnt_r;
  logic [COUNT_W-1:0]   cnt_nxt;

  // Check each axis against the threshold band
  always_comb begin
    thr_pos = $signed({{(CW-THRESH_W){1'b0}}, thresh_i});
    thr_neg = -thr_pos;
    rx      = {{(CW-SAMPLE_WIDTH){rate_x_i[SAMPLE_WIDTH-1]}}, rate_x_i};
    ry      = {{(CW-SAMPLE_WIDTH){rate_y_i[SAMPLE_WIDTH-1]}}, rate_y_i};
    rz      = {{(CW-SAMPLE_WIDTH){rate_z_i[SAMPLE_WIDTH-1]}}, rate_z_i};
    moving  = (rx > thr_pos) || (rx < thr_neg) ||
              (ry > thr_pos) || (ry < thr_neg) ||
              (rz > thr_pos) || (rz < thr_neg);
  end

  assign reached      = (cnt_r >= still_samples_i);
  assign ctl_o.moving = moving;
  assign ctl_o.track  = !moving && reached;

  // Clear on motion, hold once reached, else advance
  always_comb begin
    cnt_nxt = cnt_r;
    if (update_i) begin
      if (moving) begin
        cnt_nxt = '0;
      end else if (!reached) begin
        cnt_nxt = cnt_r + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_motion_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (update_i && moving) |=> (cnt_r == '0))
    else $error("still counter not cleared after motion");

  a_track_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (update_i && ctl_o.track) |=> $stable(cnt_r))
    else $error("still counter moved while tracking");

endmodule

`default_nettype wire

>>> rtl/gsbt_axis.sv
// ----------------------------------------------------------------------------
// gsbt_axis: bias estimate and correction for one axis
// Folds a tracked sample into the exponential average and subtracts the
// integer part of the bias (new if tracking) from the sample, saturating.
// ----------------------------------------------------------------------------
`default_nettype none

module gsbt_axis import gsbt_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           track_i,
  input  wire logic                           update_i,
  input  wire logic        [ALPHA_W-1:0]      alpha_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] rate_i,
  output logic signed      [SAMPLE_WIDTH-1:0] fixed_o
);

  localparam int BW = SAMPLE_WIDTH + FRAC_W;   // bias width
  localparam int DW = BW + 1;                  // bias minus sample
  localparam int PW = DW + ALPHA_W + 1;        // weighted difference
  localparam int OW = SAMPLE_WIDTH + 1;        // raw correction

  localparam logic signed [OW-1:0] SAT_HI = OW'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [OW-1:0] SAT_LO = -SAT_HI - OW'(1);

  logic signed [BW-1:0] bias_r;
  logic signed [BW-1:0] bias_nxt;
  logic signed [BW-1:0] bias_use;
  logic signed [DW-1:0] samp_q;
  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] upd;
  logic signed [OW-1:0] corr;

  // new = sample + floor(alpha * (old - sample) / 2^16)
  always_comb begin
    samp_q = {rate_i[SAMPLE_WIDTH-1], rate_i, {FRAC_W{1'b0}}};
    diff   = {bias_r[BW-1], bias_r} - samp_q;
    prod   = PW'(diff) * PW'($signed({1'b0, alpha_i}));
    upd    = (prod >>> FRAC_W) + PW'(samp_q);
    bias_nxt = upd[BW-1:0];
    bias_use = track_i ? bias_nxt : bias_r;
  end

  // Subtract the integer bias and clamp to the sample range
  always_comb begin
    corr = {rate_i[SAMPLE_WIDTH-1], rate_i} -
           {bias_use[BW-1], bias_use[BW-1:FRAC_W]};
    if (corr > SAT_HI) begin
      fixed_o = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (corr < SAT_LO) begin
      fixed_o = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      fixed_o = corr[SAMPLE_WIDTH-1:0];
    end
  end

  // Hold the estimate; load it when a tracked sample leaves the stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
    end else if (update_i && track_i) begin
      bias_r <= bias_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/gyro_still_bias_tracker_core.sv
// A transferred sample passes the input register, then the output register.
// Throughput: one sample per cycle while the output is not stalled; the bias
// update is one multiply-add per axis between the input and output registers.
// Reset: bias estimates and still counter clear to zero, registers take their
// defaults, both stages empty; no clearing pass, samples are taken at once.
// ----------------------------------------------------------------------------
// gyro_still_bias_tracker_core: gyroscope zero-rate bias tracker
// Input register, stillness control, three axis bias units, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_still_bias_tracker_core import gsbt_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  gsbt_in_if.sink   in_ch,
  gsbt_out_if.source out_ch,
  gsbt_cfg_if.sink  cfg_ch
);

  cfg_t       cfg;
  still_ctl_t ctl;

  logic                           s1_vld_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_x_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_y_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_z_r;
  logic                           advance;
  logic                           update;
  logic signed [SAMPLE_WIDTH-1:0] fix_x;
  logic signed [SAMPLE_WIDTH-1:0] fix_y;
  logic signed [SAMPLE_WIDTH-1:0] fix_z;

  logic                           out_vld_r;
  logic signed [SAMPLE_WIDTH-1:0] out_x_r;
  logic signed [SAMPLE_WIDTH-1:0] out_y_r;
  logic signed [SAMPLE_WIDTH-1:0] out_z_r;
  logic                           out_trk_r;

  // Output register frees when empty or taken; input register when it moves on
  assign advance     = !out_vld_r || out_ch.ready;
  assign update      = s1_vld_r && advance;
  assign in_ch.ready = !s1_vld_r || advance;

  gsbt_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  gsbt_still_ctl #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_still (
    .clk             (clk),
    .rst_n           (rst_n),
    .update_i        (update),
    .rate_x_i        (s1_x_r),
    .rate_y_i        (s1_y_r),
    .rate_z_i        (s1_z_r),
    .thresh_i        (cfg.motion_threshold),
    .still_samples_i (cfg.still_samples),
    .ctl_o           (ctl)
  );

  gsbt_axis #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_axis_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .track_i  (ctl.track),
    .update_i (update),
    .alpha_i  (cfg.smoothing_alpha),
    .rate_i   (s1_x_r),
    .fixed_o  (fix_x)
  );

  gsbt_axis #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_axis_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .track_i  (ctl.track),
    .update_i (update),
    .alpha_i  (cfg.smoothing_alpha),
    .rate_i   (s1_y_r),
    .fixed_o  (fix_y)
  );

  gsbt_axis #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_axis_z (
    .clk      (clk),
    .rst_n    (rst_n),
    .track_i  (ctl.track),
    .update_i (update),
    .alpha_i  (cfg.smoothing_alpha),
    .rate_i   (s1_z_r),
    .fixed_o  (fix_z)
  );

  // Input register: capture a transferred sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_x_r <= in_ch.rate_x;
      s1_y_r <= in_ch.rate_y;
      s1_z_r <= in_ch.rate_z;
    end
  end

  // Output register: load the corrected sample, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      out_x_r   <= fix_x;
      out_y_r   <= fix_y;
      out_z_r   <= fix_z;
      out_trk_r <= ctl.track;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.fixed_x  = out_x_r;
  assign out_ch.fixed_y  = out_y_r;
  assign out_ch.fixed_z  = out_z_r;
  assign out_ch.tracking = out_trk_r;

  a_update_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    update |=> out_vld_r)
    else $error("result lost after stage transfer");

  a_full_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !advance) |-> !in_ch.ready)
    else $error("input taken while both stages are full");

  a_track_not_moving: assert property (@(posedge clk) disable iff (!rst_n)
    update |-> !(ctl.track && ctl.moving))
    else $error("bias tracked on a moving sample");

endmodule

`default_nettype wire
